FILE: design/tcc_pkg.sv
// Shared constants, transaction types and state codes of the circumcircle block
`timescale 1ns / 1ps
package tcc_pkg;

  // Coordinate and fixed-point format
  localparam int COORD_WIDTH   = 16;
  localparam int FRACTION_BITS = 8;
  localparam int RES_W         = 32;

  // Datapath widths derived from the coordinate width
  localparam int DW    = COORD_WIDTH + 1;          // vertex differences
  localparam int SQW   = 2 * DW + 1;               // sums of squares, signed
  localparam int DENW  = 2 * DW + 2;               // twice the signed area
  localparam int NUMW  = DW + SQW + 1;             // cross-product numerators
  localparam int N2W   = NUMW + FRACTION_BITS + 1; // rounded, scaled dividend
  localparam int DVW   = DENW;                     // divisor, twice |den|
  localparam int QW    = RES_W + 3;                // clamped quotient magnitude
  localparam int RW    = (N2W > DVW + QW) ? N2W : DVW + QW;
  localparam int CSW   = COORD_WIDTH + FRACTION_BITS;
  localparam int CXW   = ((QW + 1 > CSW) ? QW + 1 : CSW) + 1;
  localparam int R2W   = 2 * RES_W + 2;            // squared radius, even width
  localparam int RTW   = R2W / 2;                  // root width
  localparam int SRW   = RTW + 3;                  // root remainder
  localparam int CNT_W = $clog2((QW > RTW) ? QW : RTW);

  // Job queue
  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] third_x;
    logic signed [COORD_WIDTH-1:0] third_y;
  } in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] center_x;
    logic signed [RES_W-1:0] center_y;
    logic [RES_W-1:0]        circle_radius;
    logic                    degenerate;
    logic                    overflowed;
  } out_t;

  // One classified triangle waiting for the solver
  typedef struct packed {
    logic [N2W-1:0]                n2x;
    logic [N2W-1:0]                n2y;
    logic [DVW-1:0]                dv;
    logic                          negx;
    logic                          negy;
    logic signed [COORD_WIDTH-1:0] x1;
    logic signed [COORD_WIDTH-1:0] y1;
    logic                          degen;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_SUM,
    S_SQRT,
    S_DONE
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic div_step;
    logic mul;
    logic sum;
    logic sqrt_step;
    logic emit;
  } back_ctl_t;

endpackage

FILE: design/tcc_front.sv
// Front pipeline: differences, cross products, numerators and dividend set-up
`timescale 1ns / 1ps
module tcc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  tcc_pkg::in_t  in_data,
  output tcc_pkg::push_t push
);
  import tcc_pkg::*;

  // Stage 1: vertex differences
  logic                          v1_r;
  logic signed [COORD_WIDTH-1:0] x1_1_r, y1_1_r;
  logic signed [DW-1:0]          a_r, b_r, c_r, d_r;
  // Stage 2: sums of squares and doubled area
  logic                          v2_r;
  logic signed [COORD_WIDTH-1:0] x1_2_r, y1_2_r;
  logic signed [DW-1:0]          a2_r, b2_r, c2_r, d2_r;
  logic signed [SQW-1:0]         p_r, q_r;
  logic signed [DENW-1:0]        den2_r;
  // Stage 3: numerator products
  logic                          v3_r;
  logic signed [COORD_WIDTH-1:0] x1_3_r, y1_3_r;
  logic signed [DENW-1:0]        den3_r;
  logic signed [NUMW-1:0]        dp_r, bq_r, aq_r, cp_r;
  // Stage 4: numerators, divisor magnitude
  logic                          v4_r;
  logic signed [COORD_WIDTH-1:0] x1_4_r, y1_4_r;
  logic signed [NUMW-1:0]        nx_r, ny_r;
  logic                          dneg_r, degen_r;
  logic [DENW-2:0]               dm_r;
  // Stage 5: queued transaction
  push_t                         push_r;

  logic signed [DENW-1:0]        den_abs;
  logic [NUMW-2:0]               magx, magy;
  push_t                         push_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      push_r.valid <= 1'b0;
    end else begin
      v1_r         <= accept;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      push_r.valid <= push_nxt.valid;
    end
    // payload stages carry no reset
    x1_1_r <= in_data.first_x;
    y1_1_r <= in_data.first_y;
    a_r    <= DW'(in_data.second_x) - DW'(in_data.first_x);
    b_r    <= DW'(in_data.second_y) - DW'(in_data.first_y);
    c_r    <= DW'(in_data.third_x) - DW'(in_data.first_x);
    d_r    <= DW'(in_data.third_y) - DW'(in_data.first_y);

    x1_2_r <= x1_1_r;
    y1_2_r <= y1_1_r;
    a2_r   <= a_r;
    b2_r   <= b_r;
    c2_r   <= c_r;
    d2_r   <= d_r;
    p_r    <= SQW'(a_r) * SQW'(a_r) + SQW'(b_r) * SQW'(b_r);
    q_r    <= SQW'(c_r) * SQW'(c_r) + SQW'(d_r) * SQW'(d_r);
    den2_r <= (DENW'(a_r) * DENW'(d_r) - DENW'(b_r) * DENW'(c_r)) <<< 1;

    x1_3_r <= x1_2_r;
    y1_3_r <= y1_2_r;
    den3_r <= den2_r;
    dp_r   <= NUMW'(d2_r) * NUMW'(p_r);
    bq_r   <= NUMW'(b2_r) * NUMW'(q_r);
    aq_r   <= NUMW'(a2_r) * NUMW'(q_r);
    cp_r   <= NUMW'(c2_r) * NUMW'(p_r);

    x1_4_r  <= x1_3_r;
    y1_4_r  <= y1_3_r;
    nx_r    <= dp_r - bq_r;
    ny_r    <= aq_r - cp_r;
    dneg_r  <= den3_r[DENW-1];
    degen_r <= (den3_r == '0);
    dm_r    <= den_abs[DENW-2:0];

    push_r.job <= push_nxt.job;
  end

  // Magnitude of the doubled area
  always_comb begin
    den_abs = den3_r[DENW-1] ? -den3_r : den3_r;
  end

  // Rounded dividend: |num| * 2^(F+1) + |den|, over divisor 2*|den|
  always_comb begin
    magx = (NUMW-1)'(nx_r[NUMW-1] ? -nx_r : nx_r);
    magy = (NUMW-1)'(ny_r[NUMW-1] ? -ny_r : ny_r);
    push_nxt.valid    = v4_r;
    push_nxt.job.n2x  = (N2W'(magx) << (FRACTION_BITS + 1)) + N2W'(dm_r);
    push_nxt.job.n2y  = (N2W'(magy) << (FRACTION_BITS + 1)) + N2W'(dm_r);
    push_nxt.job.dv   = {dm_r, 1'b0};
    push_nxt.job.negx = nx_r[NUMW-1] ^ dneg_r;
    push_nxt.job.negy = ny_r[NUMW-1] ^ dneg_r;
    push_nxt.job.x1   = x1_4_r;
    push_nxt.job.y1   = y1_4_r;
    push_nxt.job.degen = degen_r;
  end

  assign push = push_r;

endmodule

FILE: design/tcc_queue.sv
// Job queue between the front pipeline and the solver
`timescale 1ns / 1ps
module tcc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  tcc_pkg::push_t push,
  input  logic           pop,
  output tcc_pkg::job_t  head,
  output logic           empty
);
  import tcc_pkg::*;

  job_t           ent_r [QDEPTH];
  logic [QAW-1:0] wr_r, rd_r;
  logic [QCW-1:0] cnt_r, cnt_nxt;

  // Occupancy; the credit count in the top level keeps it from overrunning
  always_comb begin
    cnt_nxt = cnt_r + QCW'(push.valid) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push.valid) wr_r <= wr_r + 1'b1;
      if (pop)        rd_r <= rd_r + 1'b1;
    end
    if (push.valid) ent_r[wr_r] <= push.job;
  end

  assign head  = ent_r[rd_r];
  assign empty = (cnt_r == '0);

endmodule

FILE: design/tcc_back.sv
// Solver: shared restoring divider, squarer and bit-serial square root
`timescale 1ns / 1ps
module tcc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  tcc_pkg::job_t head,
  input  logic          empty,
  output logic          pop,
  output logic          out_valid,
  output tcc_pkg::out_t out_data
);
  import tcc_pkg::*;

  back_state_t             state_r, state_nxt;
  back_ctl_t               ctl;

  logic                    negx_r, negy_r, degen_r, satx_r, saty_r, big_r;
  logic signed [COORD_WIDTH-1:0] x1_r, y1_r;
  logic [RW-1:0]           remx_r, remy_r, dvs_r;
  logic [QW-1:0]           qx_r, qy_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [2*RES_W-1:0]      sqx_r, sqy_r;
  logic signed [CXW-1:0]   cx_r, cy_r;
  logic [R2W-1:0]          r2_r;
  logic [SRW-1:0]          srem_r;
  logic [RTW-1:0]          root_r;
  out_t                    out_r, out_nxt;
  logic                    out_valid_r;

  logic                    gex, gey, ges;
  logic [QW-1:0]           qfx, qfy;
  logic signed [CXW-1:0]   uxs, uys;
  logic [SRW-1:0]          remt, trial;
  logic [RTW:0]            rnd;
  logic                    ovf;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (!empty) state_nxt = head.degen ? S_DONE : S_DIV;
      S_DIV:  if (cnt_r == CNT_W'(QW - 1)) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_SQRT;
      S_SQRT: if (cnt_r == CNT_W'(RTW - 1)) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctl = '0;
    case (state_r)
      S_IDLE: ctl.pop       = !empty;
      S_DIV:  ctl.div_step  = 1'b1;
      S_MUL:  ctl.mul       = 1'b1;
      S_SUM:  ctl.sum       = 1'b1;
      S_SQRT: ctl.sqrt_step = 1'b1;
      S_DONE: ctl.emit      = 1'b1;
      default: ctl = '0;
    endcase
  end

  // Datapath helpers
  always_comb begin
    gex   = (remx_r >= dvs_r);
    gey   = (remy_r >= dvs_r);
    qfx   = satx_r ? '1 : qx_r;
    qfy   = saty_r ? '1 : qy_r;
    uxs   = $signed(CXW'(qfx));
    uys   = $signed(CXW'(qfy));
    if (negx_r) uxs = -uxs;
    if (negy_r) uys = -uys;
    remt  = {srem_r[SRW-3:0], r2_r[R2W-1:R2W-2]};
    trial = SRW'({root_r, 2'b01});
    ges   = (remt >= trial);
  end

  // Result: round the root to nearest, saturate all three values
  always_comb begin
    ovf = 1'b0;
    rnd = (RTW + 1)'(root_r) + (RTW + 1)'(srem_r > SRW'(root_r));
    out_nxt = '0;
    if (big_r || (rnd[RTW:RES_W] != '0)) begin
      out_nxt.circle_radius = '1;
      ovf = 1'b1;
    end else begin
      out_nxt.circle_radius = rnd[RES_W-1:0];
    end
    if (cx_r[CXW-1:RES_W-1] == '0 || cx_r[CXW-1:RES_W-1] == '1) begin
      out_nxt.center_x = cx_r[RES_W-1:0];
    end else begin
      out_nxt.center_x = cx_r[CXW-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
      ovf = 1'b1;
    end
    if (cy_r[CXW-1:RES_W-1] == '0 || cy_r[CXW-1:RES_W-1] == '1) begin
      out_nxt.center_y = cy_r[RES_W-1:0];
    end else begin
      out_nxt.center_y = cy_r[CXW-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
      ovf = 1'b1;
    end
    out_nxt.overflowed = ovf;
    if (degen_r) begin
      out_nxt = '0;
      out_nxt.degenerate = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ctl.emit;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      negx_r  <= head.negx;
      negy_r  <= head.negy;
      degen_r <= head.degen;
      x1_r    <= head.x1;
      y1_r    <= head.y1;
      remx_r  <= RW'(head.n2x);
      remy_r  <= RW'(head.n2y);
      dvs_r   <= RW'(head.dv) << (QW - 1);
      satx_r  <= (RW'(head.n2x) >= (RW'(head.dv) << QW));
      saty_r  <= (RW'(head.n2y) >= (RW'(head.dv) << QW));
      qx_r    <= '0;
      qy_r    <= '0;
      cnt_r   <= '0;
    end
    // one quotient bit of both offsets per cycle
    if (ctl.div_step) begin
      if (gex) remx_r <= remx_r - dvs_r;
      if (gey) remy_r <= remy_r - dvs_r;
      qx_r  <= {qx_r[QW-2:0], gex};
      qy_r  <= {qy_r[QW-2:0], gey};
      dvs_r <= dvs_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end
    // squares and centre sums
    if (ctl.mul) begin
      big_r <= (qfx[QW-1:RES_W] != '0) || (qfy[QW-1:RES_W] != '0);
      sqx_r <= qfx[RES_W-1:0] * qfx[RES_W-1:0];
      sqy_r <= qfy[RES_W-1:0] * qfy[RES_W-1:0];
      cx_r  <= uxs + (CXW'(x1_r) <<< FRACTION_BITS);
      cy_r  <= uys + (CXW'(y1_r) <<< FRACTION_BITS);
    end
    if (ctl.sum) begin
      r2_r   <= R2W'(sqx_r) + R2W'(sqy_r);
      srem_r <= '0;
      root_r <= '0;
      cnt_r  <= '0;
    end
    // one root bit per cycle
    if (ctl.sqrt_step) begin
      srem_r <= ges ? remt - trial : remt;
      root_r <= {root_r[RTW-2:0], ges};
      r2_r   <= r2_r << 2;
      cnt_r  <= cnt_r + 1'b1;
    end
    if (ctl.emit) out_r <= out_nxt;
  end

  assign pop       = ctl.pop;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: design/triangle_circumcircle_top.sv
// Top level of the triangle circumcircle block
//
//  channel  ports                   handshake
//  input    start, busy, in_data    transaction taken when start high and busy low
//  result   out_valid, out_data     one-cycle strobe, cannot be held off
//
// A transaction passes a five-stage front pipeline into an eight-entry job queue.
// The solver takes 35 divide steps, 33 root steps and the set-up and result states per
// triangle, only the set-up and result states for a collinear one; that unit sets
// the sustained rate. Input is taken every cycle until eight transactions are
// queued or in the front pipeline; busy then stays high until the solver frees one.
// Synchronous reset empties the pipeline and queue and drops the strobe.
`timescale 1ns / 1ps
module triangle_circumcircle_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  tcc_pkg::in_t  in_data,
  output logic          out_valid,
  output tcc_pkg::out_t out_data
);
  import tcc_pkg::*;

  logic           accept, pop, empty;
  logic [QCW-1:0] credit_r, credit_nxt;
  push_t          push;
  job_t           head;

  // Credit count: transactions taken but not yet handed to the solver
  always_comb begin
    accept     = start && !busy;
    credit_nxt = credit_r + QCW'(accept) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) credit_r <= '0;
    else        credit_r <= credit_nxt;
  end

  assign busy = (credit_r == QCW'(QDEPTH));

  tcc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .push    (push)
  );

  tcc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .empty (empty)
  );

  tcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: design/tcc_checker.sv
// Port checker for the circumcircle block, bound to the top level
`timescale 1ns / 1ps
module tcc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input tcc_pkg::in_t  in_data,
  input logic          out_valid,
  input tcc_pkg::out_t out_data
);
  import tcc_pkg::*;

  // reset leaves the block free and silent
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or strobe after reset");

  // the solver never produces results in consecutive cycles
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a collinear triangle gives all-zero values and no overflow
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.center_x == '0 && out_data.center_y == '0 &&
      out_data.circle_radius == '0 && !out_data.overflowed)
    else $error("degenerate result with nonzero fields");

  // the queue only fills up through an accepted transaction
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted transaction");

endmodule

bind triangle_circumcircle_top tcc_checker u_tcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

FILE: verif/triangle_circumcircle_top_test.sv
// Self-checking testbench for the triangle circumcircle block: directed and random triangles
`timescale 1ns / 1ps
module triangle_circumcircle_top_test;
  import tcc_pkg::*;

  typedef struct {
    in_t item;
    int  phase;
    bit  drain;
  } pending_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  pending_t triangle_q[$];
  out_t     circle_q[$];
  bit       taken;
  int       mismatches;
  int       fail_count;

  triangle_circumcircle_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // Offset from the first vertex, scaled and rounded with ties away from zero
  function automatic logic signed [127:0] scaled_offset(logic signed [127:0] num,
                                                        logic signed [127:0] den);
    logic [127:0] n;
    logic [127:0] dm;
    logic [127:0] quo;
    logic         neg;
    neg = (num < 0) != (den < 0);
    dm  = (den < 0) ? -den : den;
    n   = (num < 0) ? -num : num;
    n   = ((n << FRACTION_BITS) << 1) + dm;
    quo = n / (dm << 1);
    return neg ? -$signed(quo) : $signed(quo);
  endfunction

  // Clamp to signed 32 bits
  function automatic logic [31:0] clamp_s32(logic signed [127:0] v, inout bit ovf);
    logic signed [127:0] lim;
    lim = 128'sd1 <<< 31;
    if (v < -lim) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    if (v > lim - 1) begin
      ovf = 1'b1;
      return 32'h7fff_ffff;
    end
    return v[31:0];
  endfunction

  // Expected circle of one triangle
  function automatic out_t circle_of(in_t t);
    logic signed [127:0] x1, y1, a, b, c, d, p, q, den, nx, ny, ux, uy;
    logic [127:0]        ax, ay, r2, r, cand;
    bit                  ovf;
    out_t                res;
    x1  = t.first_x;
    y1  = t.first_y;
    a   = $signed(t.second_x) - x1;
    b   = $signed(t.second_y) - y1;
    c   = $signed(t.third_x) - x1;
    d   = $signed(t.third_y) - y1;
    p   = a * a + b * b;
    q   = c * c + d * d;
    den = 2 * (a * d - b * c);
    res = '0;
    ovf = 1'b0;
    if (den == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    nx = d * p - b * q;
    ny = a * q - c * p;
    ux = scaled_offset(nx, den);
    uy = scaled_offset(ny, den);
    res.center_x = clamp_s32(ux + (x1 <<< FRACTION_BITS), ovf);
    res.center_y = clamp_s32(uy + (y1 <<< FRACTION_BITS), ovf);
    ax = (ux < 0) ? -ux : ux;
    ay = (uy < 0) ? -uy : uy;
    if (ax >= (128'd1 << 32) || ay >= (128'd1 << 32)) begin
      ovf = 1'b1;
      res.circle_radius = 32'hffff_ffff;
    end else begin
      r2 = ax * ax + ay * ay;
      r  = '0;
      for (int bitn = 33; bitn >= 0; bitn--) begin
        cand = r | (128'd1 << bitn);
        if (cand * cand <= r2) r = cand;
      end
      // round to nearest, ties up
      if (r2 - r * r > r) r = r + 1;
      if (r > 128'hffff_ffff) begin
        ovf = 1'b1;
        res.circle_radius = 32'hffff_ffff;
      end else begin
        res.circle_radius = r[31:0];
      end
    end
    res.overflowed = ovf;
    return res;
  endfunction

  function automatic in_t make_tri(int x1, int y1, int x2, int y2, int x3, int y3);
    in_t t;
    t.first_x  = x1[15:0];
    t.first_y  = y1[15:0];
    t.second_x = x2[15:0];
    t.second_y = y2[15:0];
    t.third_x  = x3[15:0];
    t.third_y  = y3[15:0];
    return t;
  endfunction

  function automatic int srand(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // Random triangle: small well-formed ones, plus fully random, collinear and near-collinear ones
  function automatic in_t random_tri();
    int x, y, dx, dy, k1, k2, sel;
    in_t t;
    sel = $urandom_range(99);
    x   = srand(30000);
    y   = srand(30000);
    if (sel < 30) begin
      t = in_t'({$urandom, $urandom, $urandom});
    end else if (sel < 70) begin
      t = make_tri(x, y, x + srand(200), y + srand(200), x + srand(200), y + srand(200));
    end else begin
      x  = srand(10000);
      y  = srand(10000);
      dx = srand(50);
      dy = srand(50);
      k1 = srand(100);
      k2 = srand(100);
      t  = make_tri(x, y, x + k1 * dx, y + k1 * dy, x + k2 * dx, y + k2 * dy);
      if (sel >= 85) t.third_x = t.third_x + 16'sd1;
    end
    return t;
  endfunction

  // Stimulus
  initial begin
    in_t dir[$];
    pending_t pe;
    dir.push_back(make_tri(0, 0, 0, 0, 0, 0));
    dir.push_back(make_tri(0, 0, 4, 0, 0, 3));
    dir.push_back(make_tri(0, 0, 1, 0, 0, 1));
    dir.push_back(make_tri(1, 1, 2, 2, 3, 3));
    dir.push_back(make_tri(-32768, -32768, 32767, 32767, 0, 0));
    dir.push_back(make_tri(-32768, -32768, 32767, -32768, -32768, 32767));
    dir.push_back(make_tri(32767, 32767, -32768, 32767, 32767, -32768));
    dir.push_back(make_tri(-32768, 32767, 32767, -32768, -32768, -32768));
    dir.push_back(make_tri(-32768, -32768, 32767, -32767, -32767, -32768));
    dir.push_back(make_tri(0, 0, 65535 / 2, 1, -32768, 0));
    dir.push_back(make_tri(0, 0, 32767, 0, -32768, 1));
    dir.push_back(make_tri(-32768, 0, 32767, 1, 0, 0));
    dir.push_back(make_tri(5, 5, 6, 5, 5, 7));
    dir.push_back(make_tri(-1, -1, 1, -1, 0, 1));
    dir.push_back(make_tri(32767, 32767, 32766, 32767, 32767, 32766));
    dir.push_back(make_tri(-32768, -32768, -32767, -32768, -32768, -32767));
    dir.push_back(make_tri(100, 200, 300, 400, 100, 200));
    dir.push_back(make_tri(-7, 3, -7, 3, 9, -2));
    dir.push_back(make_tri(0, 0, 3, 1, 6, 2));
    dir.push_back(make_tri(1000, -1000, -1000, 1000, 1000, 1000));
    dir.push_back(in_t'({96{1'b1}}));
    dir.push_back(in_t'({48{2'b10}}));
    foreach (dir[i]) begin
      pe.item  = dir[i];
      pe.phase = 0;
      pe.drain = 1'b0;
      triangle_q.push_back(pe);
    end
    for (int i = 0; i < 850; i++) begin
      pe.item  = random_tri();
      pe.phase = (i < 300) ? 0 : (i < 600) ? 1 : 2;
      // wait for the solver to drain at each phase change
      pe.drain = (i == 300) || (i == 600);
      triangle_q.push_back(pe);
    end
  end

  // Driver: drives at the falling edge
  always @(negedge clk) begin
    logic go;
    int   idle_pct;
    bit   was_taken;
    was_taken = taken;
    if (taken) begin
      void'(triangle_q.pop_front());
      taken = 1'b0;
    end
    go = 1'b0;
    if (rst_n && triangle_q.size() > 0) begin
      idle_pct = (triangle_q[0].phase == 0) ? 29 : (triangle_q[0].phase == 1) ? 76 : 0;
      // hold a transaction that is still waiting on busy
      if (start && !was_taken) go = 1'b1;
      else if (triangle_q[0].drain && circle_q.size() > 0) go = 1'b0;
      else go = ($urandom_range(99) >= idle_pct);
      if (go) triangle_q[0].drain = 1'b0;
    end
    start <= go;
    if (go) in_data <= triangle_q[0].item;
  end

  initial begin
    start   = 1'b0;
    in_data = '0;
  end

  // Accepted transactions and checking at the rising edge
  always @(posedge clk) begin
    out_t want;
    if (rst_n && start && !busy) begin
      circle_q.push_back(circle_of(in_data));
      taken = 1'b1;
    end
    if (rst_n && out_valid) begin
      if (circle_q.size() == 0) begin
        fail_count++;
        if (mismatches < 10) $display("unexpected result %p", out_data);
        mismatches++;
      end else begin
        want = circle_q.pop_front();
        if (out_data.center_x !== want.center_x || out_data.center_y !== want.center_y ||
            out_data.circle_radius !== want.circle_radius ||
            out_data.degenerate !== want.degenerate ||
            out_data.overflowed !== want.overflowed) begin
          fail_count++;
          if (mismatches < 10)
            $display({"mismatch: expected cx=%0d cy=%0d r=%0d dg=%0b ov=%0b,",
                      " got cx=%0d cy=%0d r=%0d dg=%0b ov=%0b"},
                     want.center_x, want.center_y, want.circle_radius, want.degenerate,
                     want.overflowed, out_data.center_x, out_data.center_y,
                     out_data.circle_radius, out_data.degenerate, out_data.overflowed);
          mismatches++;
        end
      end
    end
  end

  // End of run
  initial begin
    wait (rst_n === 1'b1);
    @(posedge clk);
    while (triangle_q.size() != 0 || taken || circle_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && circle_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
